// ===== src/fvn_pkg.sv =====
// Shared widths, constants, lookup tables and beat type for the fractal value noise block.
package fvn_pkg;

	localparam int MAX_OCTAVES      = 8;
	localparam int BASE_SCALE_SHIFT = 6;
	localparam int FRAC_BITS        = 40;

	localparam int COORD_W = 16;
	localparam int LAT_W   = 32;
	localparam int OCT_W   = $clog2(MAX_OCTAVES + 1);
	localparam int CNT_W   = 4;

	// lattice/fraction split of a coordinate shifted left by the octave index
	localparam int FIDX_W  = BASE_SCALE_SHIFT;
	localparam int SCALE_W = LAT_W + BASE_SCALE_SHIFT;

	// weight table: one entry per fraction step, both ends included
	localparam int WT_N   = (1 << BASE_SCALE_SHIFT) + 1;
	localparam int WTIX_W = $clog2(WT_N);
	localparam int WGT_W  = FRAC_BITS + 1;

	// signed values (corners, blends) and the running sum
	localparam int VAL_W = FRAC_BITS + 4;
	localparam int MAG_W = VAL_W - 1;
	localparam int SUM_W = FRAC_BITS + 4;

	// split multiplier operands
	localparam int MAG_LO_W = (MAG_W + 1) / 2;
	localparam int MAG_HI_W = MAG_W - MAG_LO_W;
	localparam int WGT_LO_W = (WGT_W + 1) / 2;
	localparam int WGT_HI_W = WGT_W - WGT_LO_W;
	localparam int PROD_W   = MAG_W + WGT_W;

	// hash constants
	localparam logic [LAT_W-1:0] HASH_Y_MUL = 32'd57;
	localparam int               HASH_SHL   = 13;
	localparam logic [LAT_W-1:0] HASH_MUL   = 32'd15731;
	localparam logic [LAT_W-1:0] HASH_ADD1  = 32'd789221;
	localparam logic [LAT_W-1:0] HASH_ADD2  = 32'd1376312589;
	localparam int               HASH_M_W   = 31;
	localparam int               HASH_M_SHL = FRAC_BITS - 30;

	localparam logic [VAL_W-1:0]  ONE_VAL = VAL_W'(1) << FRAC_BITS;
	localparam logic [PROD_W-1:0] ONE_P   = PROD_W'(1) << FRAC_BITS;
	localparam logic [PROD_W-1:0] DECAY_P = PROD_W'(64'd1088516511498);

	localparam int HASH_LAT = 6;
	localparam int MUL_LAT  = 4;
	localparam int CELL_LAT = 1 + HASH_LAT + MUL_LAT + 1 + MUL_LAT + 1 + 1 + 1;

	// output mapping
	localparam int RV_W     = 9;
	localparam int EXP_N    = 256;
	localparam int EXP_IX_W = 8;
	localparam int BYTE_W   = 8;
	localparam int SCL_W    = SUM_W + 8;

	typedef logic [WGT_W-1:0]  wt_lut_t  [WT_N];
	typedef logic [BYTE_W-1:0] exp_lut_t [EXP_N];

	typedef struct packed {
		logic                    valid;
		logic [COORD_W-1:0]      x;
		logic [COORD_W-1:0]      y;
		logic signed [SUM_W-1:0] sum;
	} beat_t;

	function automatic logic [PROD_W-1:0] mul_frac(logic [PROD_W-1:0] a, logic [PROD_W-1:0] b);
		logic [2*PROD_W-1:0] p;
		p = a * b;
		return p[FRAC_BITS +: PROD_W];
	endfunction

	function automatic logic [WGT_W-1:0] smooth_fx(logic [PROD_W-1:0] t);
		logic [PROD_W-1:0] sq;
		logic [PROD_W-1:0] r;
		sq = mul_frac(t, t);
		r  = mul_frac(sq, (ONE_P * 3) - (t << 1));
		return r[WGT_W-1:0];
	endfunction

	function automatic wt_lut_t build_wt();
		wt_lut_t r;
		for (int j = 0; j < WT_N; j++) begin
			r[j] = smooth_fx(PROD_W'(j) << (FRAC_BITS - BASE_SCALE_SHIFT));
		end
		return r;
	endfunction

	function automatic exp_lut_t build_exp(int base);
		exp_lut_t          r;
		logic [PROD_W-1:0] p;
		logic [PROD_W-1:0] b;
		p = ONE_P;
		for (int k = 0; k < base + EXP_N; k++) begin
			if (k >= base) begin
				b = ((ONE_P - p) * 255) >> FRAC_BITS;
				r[k - base] = b[BYTE_W-1:0];
			end
			p = mul_frac(p, DECAY_P);
		end
		return r;
	endfunction

	localparam wt_lut_t  WT_LUT  = build_wt();
	localparam exp_lut_t EXP_LO  = build_exp(0);
	localparam exp_lut_t EXP_HI  = build_exp(EXP_N);

endpackage

// ===== src/fractal_value_noise_2d.sv =====
// Fractal value noise: a row of octave cells followed by the exponential output mapping.
//
// Takes one coordinate word per cycle unless the pipeline holds, and returns one noise byte
// per word, in order. Each of the eight octave cells is a 19-stage pipeline (corner hash,
// two blend multiplies, weighted accumulate) and hands its running sum to the next cell
// every cycle unless the pipeline holds; two more stages map the sum to the output byte.
// Octaves beyond octave_count pass the sum through unchanged. A skid stage at the output
// keeps input flowing while a result waits; when both it and the output register are
// full the whole pipeline holds. octave_count is written through cfg_valid/cfg_data and
// must only change while the block is empty.
module fractal_value_noise_2d (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [31:0]                s_tdata,   // [15:0] coord_x, [31:16] coord_y
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [7:0]                 m_tdata,   // [7:0] noise_byte
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [fvn_pkg::CNT_W-1:0]  cfg_data
);

	logic [fvn_pkg::CNT_W-1:0]  oct_q;
	logic                       en;
	fvn_pkg::beat_t             beat [fvn_pkg::MAX_OCTAVES + 1];

	logic signed [fvn_pkg::SUM_W-1:0] fsum;
	logic [fvn_pkg::SCL_W-1:0]        scaled;
	logic [fvn_pkg::RV_W-1:0]         rv;
	logic [fvn_pkg::RV_W-1:0]         rv_s1;
	logic                             v_s1, v_s2;
	logic [fvn_pkg::BYTE_W-1:0]       byte_s2;
	logic [fvn_pkg::BYTE_W-1:0]       out_q, sk_q;
	logic                             out_v_q, sk_v_q;
	logic                             new_v;

	assign cfg_ready = 1'b1;
	assign en        = !sk_v_q;
	assign s_tready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oct_q <= fvn_pkg::CNT_W'(4);
		end else if (cfg_valid) begin
			oct_q <= cfg_data;
		end
	end

	assign beat[0].valid = s_tvalid;
	assign beat[0].x     = s_tdata[15:0];
	assign beat[0].y     = s_tdata[31:16];
	assign beat[0].sum   = '0;

	for (genvar i = 0; i < fvn_pkg::MAX_OCTAVES; i++) begin : g_cell
		fvn_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.active  (fvn_pkg::CNT_W'(i) < oct_q),
			.octave  (fvn_pkg::OCT_W'(i)),
			.in_beat (beat[i]),
			.out_beat(beat[i+1])
		);
	end

	// sum*255 as a shift and subtract; drop non-positive sums, saturate the index
	assign fsum   = beat[fvn_pkg::MAX_OCTAVES].sum;
	assign scaled = (fvn_pkg::SCL_W'(fsum) << 8) - fvn_pkg::SCL_W'(fsum);
	always_comb begin
		if (fsum <= 0) begin
			rv = '0;
		end else if (scaled[fvn_pkg::SCL_W-1:fvn_pkg::FRAC_BITS+fvn_pkg::RV_W] != '0) begin
			rv = '1;
		end else begin
			rv = scaled[fvn_pkg::FRAC_BITS +: fvn_pkg::RV_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rv_s1   <= rv;
			byte_s2 <= rv_s1[fvn_pkg::RV_W-1]
				? fvn_pkg::EXP_HI[rv_s1[fvn_pkg::EXP_IX_W-1:0]]
				: fvn_pkg::EXP_LO[rv_s1[fvn_pkg::EXP_IX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= beat[fvn_pkg::MAX_OCTAVES].valid;
			v_s2 <= v_s1;
		end
	end

	assign new_v = v_s2 && en;

	// output register with a skid word behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			if (sk_v_q) begin
				out_v_q <= 1'b1;
				sk_v_q  <= 1'b0;
			end else begin
				out_v_q <= new_v;
			end
		end else if (new_v) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			out_q <= sk_v_q ? sk_q : byte_s2;
		end else if (new_v) begin
			sk_q <= byte_s2;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

endmodule

// ===== src/fvn_hash.sv =====
// Six-stage lattice corner hash giving a signed corner value in fixed point.
module fvn_hash (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic [fvn_pkg::LAT_W-1:0]             x,
	input  logic [fvn_pkg::LAT_W-1:0]             y,
	output logic signed [fvn_pkg::VAL_W-1:0]      corner
);

	logic [fvn_pkg::LAT_W-1:0]    n;
	logic [fvn_pkg::LAT_W-1:0]    n2_s1, n2_s2, n2_s3;
	logic [fvn_pkg::LAT_W-1:0]    sq_s2;
	logic [fvn_pkg::LAT_W-1:0]    u_s3;
	logic [fvn_pkg::LAT_W-1:0]    pv_s4;
	logic [fvn_pkg::LAT_W-1:0]    mw;
	logic [fvn_pkg::HASH_M_W-1:0] m_s5;
	logic [fvn_pkg::VAL_W-1:0]    corner_s6;

	assign n  = x + y * fvn_pkg::HASH_Y_MUL;
	assign mw = pv_s4 + fvn_pkg::HASH_ADD2;

	always_ff @(posedge clk) begin
		if (en) begin
			n2_s1     <= (n << fvn_pkg::HASH_SHL) ^ n;
			sq_s2     <= n2_s1 * n2_s1;
			n2_s2     <= n2_s1;
			u_s3      <= sq_s2 * fvn_pkg::HASH_MUL + fvn_pkg::HASH_ADD1;
			n2_s3     <= n2_s2;
			pv_s4     <= n2_s3 * u_s3;
			m_s5      <= mw[fvn_pkg::HASH_M_W-1:0];
			corner_s6 <= fvn_pkg::ONE_VAL
				- (fvn_pkg::VAL_W'(m_s5) << fvn_pkg::HASH_M_SHL);
		end
	end

	assign corner = signed'(corner_s6);

endmodule

// ===== src/fvn_mulw.sv =====
// Four-stage signed value times unsigned weight, truncated toward zero to 40 fraction bits.
module fvn_mulw (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [fvn_pkg::VAL_W-1:0]      a,
	input  logic [fvn_pkg::WGT_W-1:0]             w,
	output logic signed [fvn_pkg::VAL_W-1:0]      y
);

	logic [fvn_pkg::MAG_W-1:0]                      mag_s1;
	logic                                           neg_s1, neg_s2, neg_s3;
	logic [fvn_pkg::WGT_W-1:0]                      w_s1;
	logic [fvn_pkg::MAG_HI_W+fvn_pkg::WGT_HI_W-1:0] hh_s2;
	logic [fvn_pkg::MAG_HI_W+fvn_pkg::WGT_LO_W-1:0] hl_s2;
	logic [fvn_pkg::MAG_LO_W+fvn_pkg::WGT_HI_W-1:0] lh_s2;
	logic [fvn_pkg::MAG_LO_W+fvn_pkg::WGT_LO_W-1:0] ll_s2;
	logic [fvn_pkg::PROD_W-1:0]                     full;
	logic [fvn_pkg::MAG_W-1:0]                      res_s3;
	logic [fvn_pkg::VAL_W-1:0]                      y_s4;
	logic [fvn_pkg::VAL_W-1:0]                      a_neg;

	assign a_neg = -a;

	assign full = (fvn_pkg::PROD_W'(hh_s2) << (fvn_pkg::MAG_LO_W + fvn_pkg::WGT_LO_W))
		+ (fvn_pkg::PROD_W'(hl_s2) << fvn_pkg::MAG_LO_W)
		+ (fvn_pkg::PROD_W'(lh_s2) << fvn_pkg::WGT_LO_W)
		+ fvn_pkg::PROD_W'(ll_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= a[fvn_pkg::VAL_W-1] ? a_neg[fvn_pkg::MAG_W-1:0] : a[fvn_pkg::MAG_W-1:0];
			neg_s1 <= a[fvn_pkg::VAL_W-1];
			w_s1   <= w;
			hh_s2  <= mag_s1[fvn_pkg::MAG_W-1 -: fvn_pkg::MAG_HI_W]
				* w_s1[fvn_pkg::WGT_W-1 -: fvn_pkg::WGT_HI_W];
			hl_s2  <= mag_s1[fvn_pkg::MAG_W-1 -: fvn_pkg::MAG_HI_W]
				* w_s1[fvn_pkg::WGT_LO_W-1:0];
			lh_s2  <= mag_s1[fvn_pkg::MAG_LO_W-1:0]
				* w_s1[fvn_pkg::WGT_W-1 -: fvn_pkg::WGT_HI_W];
			ll_s2  <= mag_s1[fvn_pkg::MAG_LO_W-1:0] * w_s1[fvn_pkg::WGT_LO_W-1:0];
			neg_s2 <= neg_s1;
			res_s3 <= full[fvn_pkg::FRAC_BITS +: fvn_pkg::MAG_W];
			neg_s3 <= neg_s2;
			y_s4   <= neg_s3 ? -fvn_pkg::VAL_W'(res_s3) : fvn_pkg::VAL_W'(res_s3);
		end
	end

	assign y = signed'(y_s4);

endmodule

// ===== src/fvn_cell.sv =====
// Octave cell: hashes and blends four corners; if active, adds the weighted value to the sum.
module fvn_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      active,
	input  logic [fvn_pkg::OCT_W-1:0] octave,
	input  fvn_pkg::beat_t            in_beat,
	output fvn_pkg::beat_t            out_beat
);

	localparam int L = fvn_pkg::CELL_LAT;

	logic [fvn_pkg::SCALE_W-1:0] sx, sy;
	logic [fvn_pkg::LAT_W-1:0]   lx_s1, lx1_s1, ly_s1, ly1_s1;
	logic [fvn_pkg::FIDX_W-1:0]  jx_d [fvn_pkg::HASH_LAT + 1];
	logic [fvn_pkg::FIDX_W-1:0]  jy_d [fvn_pkg::HASH_LAT + fvn_pkg::MUL_LAT + 2];
	logic [fvn_pkg::COORD_W-1:0] x_d  [L];
	logic [fvn_pkg::COORD_W-1:0] y_d  [L];
	logic                        v_d  [L];
	logic signed [fvn_pkg::SUM_W-1:0] sum_d [L - 1];

	logic signed [fvn_pkg::VAL_W-1:0] c00, c10, c01, c11;
	logic signed [fvn_pkg::VAL_W-1:0] p00, p10, p01, p11;
	logic signed [fvn_pkg::VAL_W-1:0] top_s12, bot_s12;
	logic signed [fvn_pkg::VAL_W-1:0] pt, pb;
	logic signed [fvn_pkg::VAL_W-1:0] v_s17;
	logic [fvn_pkg::MAG_W-1:0]        vmag_s18;
	logic                             vneg_s18;
	logic signed [fvn_pkg::SUM_W-1:0] sum_s19;
	logic [fvn_pkg::SUM_W-1:0]        part;
	logic [fvn_pkg::VAL_W-1:0]        v_neg;

	logic [fvn_pkg::WTIX_W-1:0] ix_x, ixn_x, ix_y, ixn_y;
	logic [fvn_pkg::WGT_W-1:0]  wx, wnx, wy, wny;

	// lattice coordinate and fraction index both come from one left shift
	assign sx = fvn_pkg::SCALE_W'(in_beat.x) << octave;
	assign sy = fvn_pkg::SCALE_W'(in_beat.y) << octave;

	assign ix_x  = fvn_pkg::WTIX_W'(jx_d[fvn_pkg::HASH_LAT]);
	assign ixn_x = fvn_pkg::WTIX_W'(fvn_pkg::WT_N - 1) - ix_x;
	assign ix_y  = fvn_pkg::WTIX_W'(jy_d[fvn_pkg::HASH_LAT + fvn_pkg::MUL_LAT + 1]);
	assign ixn_y = fvn_pkg::WTIX_W'(fvn_pkg::WT_N - 1) - ix_y;
	assign wx    = fvn_pkg::WT_LUT[ix_x];
	assign wnx   = fvn_pkg::WT_LUT[ixn_x];
	assign wy    = fvn_pkg::WT_LUT[ix_y];
	assign wny   = fvn_pkg::WT_LUT[ixn_y];

	fvn_hash u_h00 (.clk(clk), .en(en), .x(lx_s1),  .y(ly_s1),  .corner(c00));
	fvn_hash u_h10 (.clk(clk), .en(en), .x(lx1_s1), .y(ly_s1),  .corner(c10));
	fvn_hash u_h01 (.clk(clk), .en(en), .x(lx_s1),  .y(ly1_s1), .corner(c01));
	fvn_hash u_h11 (.clk(clk), .en(en), .x(lx1_s1), .y(ly1_s1), .corner(c11));

	fvn_mulw u_m00 (.clk(clk), .en(en), .a(c00), .w(wnx), .y(p00));
	fvn_mulw u_m10 (.clk(clk), .en(en), .a(c10), .w(wx),  .y(p10));
	fvn_mulw u_m01 (.clk(clk), .en(en), .a(c01), .w(wnx), .y(p01));
	fvn_mulw u_m11 (.clk(clk), .en(en), .a(c11), .w(wx),  .y(p11));

	fvn_mulw u_mt (.clk(clk), .en(en), .a(top_s12), .w(wny), .y(pt));
	fvn_mulw u_mb (.clk(clk), .en(en), .a(bot_s12), .w(wy),  .y(pb));

	assign v_neg = -v_s17;
	assign part  = fvn_pkg::SUM_W'(vmag_s18) >> octave;

	always_ff @(posedge clk) begin
		if (en) begin
			lx_s1  <= sx[fvn_pkg::BASE_SCALE_SHIFT +: fvn_pkg::LAT_W];
			lx1_s1 <= sx[fvn_pkg::BASE_SCALE_SHIFT +: fvn_pkg::LAT_W] + 1'b1;
			ly_s1  <= sy[fvn_pkg::BASE_SCALE_SHIFT +: fvn_pkg::LAT_W];
			ly1_s1 <= sy[fvn_pkg::BASE_SCALE_SHIFT +: fvn_pkg::LAT_W] + 1'b1;
			jx_d[0] <= sx[fvn_pkg::FIDX_W-1:0];
			jy_d[0] <= sy[fvn_pkg::FIDX_W-1:0];
			for (int k = 1; k < fvn_pkg::HASH_LAT + 1; k++) begin
				jx_d[k] <= jx_d[k-1];
			end
			for (int k = 1; k < fvn_pkg::HASH_LAT + fvn_pkg::MUL_LAT + 2; k++) begin
				jy_d[k] <= jy_d[k-1];
			end
			x_d[0]   <= in_beat.x;
			y_d[0]   <= in_beat.y;
			sum_d[0] <= in_beat.sum;
			for (int k = 1; k < L; k++) begin
				x_d[k] <= x_d[k-1];
				y_d[k] <= y_d[k-1];
			end
			for (int k = 1; k < L - 1; k++) begin
				sum_d[k] <= sum_d[k-1];
			end
			top_s12  <= p00 + p10;
			bot_s12  <= p01 + p11;
			v_s17    <= pt + pb;
			vmag_s18 <= v_s17[fvn_pkg::VAL_W-1] ? v_neg[fvn_pkg::MAG_W-1:0]
				: v_s17[fvn_pkg::MAG_W-1:0];
			vneg_s18 <= v_s17[fvn_pkg::VAL_W-1];
			// shifting the magnitude truncates toward zero
			if (!active) begin
				sum_s19 <= sum_d[L-2];
			end else if (vneg_s18) begin
				sum_s19 <= sum_d[L-2] - signed'(part);
			end else begin
				sum_s19 <= sum_d[L-2] + signed'(part);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < L; k++) begin
				v_d[k] <= 1'b0;
			end
		end else if (en) begin
			v_d[0] <= in_beat.valid;
			for (int k = 1; k < L; k++) begin
				v_d[k] <= v_d[k-1];
			end
		end
	end

	assign out_beat.valid = v_d[L-1];
	assign out_beat.x     = x_d[L-1];
	assign out_beat.y     = y_d[L-1];
	assign out_beat.sum   = sum_s19;

endmodule

// ===== verif/fvn_checker.sv =====
// Checker for the fractal value noise block: watches the channels, predicts and compares.
`timescale 1ns / 1ps

module fvn_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [31:0]               s_tdata,
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [7:0]                m_tdata,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [fvn_pkg::CNT_W-1:0] cfg_data,
	output int                        fail_count,
	output int                        pending,
	output int                        bytes_checked
);
	import fvn_pkg::*;

	localparam longint unsigned ONE_FX = 64'd1 << FRAC_BITS;
	localparam longint unsigned DECAY  = 64'd1088516511498;

	logic [CNT_W-1:0] octaves;
	logic [7:0]       expected_bytes [$];

	function automatic longint unsigned frac_mul(longint unsigned a, longint unsigned b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[FRAC_BITS +: 64];
	endfunction

	function automatic longint signed_mul(longint v, longint unsigned w);
		longint unsigned r;
		r = frac_mul((v < 0) ? longint'(-v) : v, w);
		return (v < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint lattice_value(logic [31:0] lx, logic [31:0] ly);
		logic [31:0] n;
		logic [31:0] m;
		n = lx + ly * 32'd57;
		n = (n << 13) ^ n;
		m = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
		return longint'(ONE_FX) - (longint'({32'd0, m}) << 10);
	endfunction

	function automatic longint unsigned smoothstep(longint unsigned t);
		return frac_mul(frac_mul(t, t), 3 * ONE_FX - 2 * t);
	endfunction

	function automatic longint lerp_smooth(longint a, longint b, longint unsigned f);
		return signed_mul(a, smoothstep(ONE_FX - f)) + signed_mul(b, smoothstep(f));
	endfunction

	function automatic logic [7:0] noise_byte_of(logic [15:0] cx, logic [15:0] cy,
			logic [CNT_W-1:0] cnt);
		int              n_oct;
		longint          acc;
		longint          top;
		longint          bot;
		longint          v;
		longint unsigned mag;
		longint unsigned fx;
		longint unsigned fy;
		longint unsigned lvl;
		longint unsigned p;
		logic [31:0]     lx;
		logic [31:0]     ly;
		logic [127:0]    out;
		n_oct = (cnt > MAX_OCTAVES) ? MAX_OCTAVES : cnt;
		acc = 0;
		for (int i = 0; i < n_oct; i++) begin
			if (i >= BASE_SCALE_SHIFT) begin
				lx = {16'd0, cx} << (i - BASE_SCALE_SHIFT);
				ly = {16'd0, cy} << (i - BASE_SCALE_SHIFT);
				fx = 0;
				fy = 0;
			end else begin
				lx = cx >> (BASE_SCALE_SHIFT - i);
				ly = cy >> (BASE_SCALE_SHIFT - i);
				fx = longint'(cx & ((16'd1 << (BASE_SCALE_SHIFT - i)) - 1))
					<< (FRAC_BITS - BASE_SCALE_SHIFT + i);
				fy = longint'(cy & ((16'd1 << (BASE_SCALE_SHIFT - i)) - 1))
					<< (FRAC_BITS - BASE_SCALE_SHIFT + i);
			end
			top = lerp_smooth(lattice_value(lx, ly), lattice_value(lx + 1, ly), fx);
			bot = lerp_smooth(lattice_value(lx, ly + 1), lattice_value(lx + 1, ly + 1), fx);
			v = lerp_smooth(top, bot, fy);
			mag = ((v < 0) ? longint'(-v) : v) >> i;
			acc += (v < 0) ? -longint'(mag) : longint'(mag);
		end
		lvl = (acc > 0) ? ((longint'(acc) * 255) >> FRAC_BITS) : 0;
		p = ONE_FX;
		for (longint unsigned k = 0; k < lvl; k++)
			p = frac_mul(p, DECAY);
		out = ({64'd0, ONE_FX - p} * 255) >> FRAC_BITS;
		return out[7:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [7:0] want;
		if (!arst_n) begin
			octaves = 4;
			fail_count = 0;
			bytes_checked = 0;
			expected_bytes.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				octaves = cfg_data;
			if (s_tvalid && s_tready)
				expected_bytes.push_back(noise_byte_of(s_tdata[15:0], s_tdata[31:16], octaves));
			if (m_tvalid && m_tready) begin
				if (expected_bytes.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected output word %0d", m_tdata);
				end else begin
					want = expected_bytes.pop_front();
					bytes_checked++;
					if (want !== m_tdata) begin
						fail_count++;
						if (fail_count <= 10)
							$display("noise_byte mismatch: expected %0d, got %0d", want, m_tdata);
					end
				end
			end
		end
		pending = expected_bytes.size();
	end

endmodule

// ===== verif/testbench.sv =====
// Testbench top: stimulus, receiver stalls, watchdog and verdict for the noise block.
`timescale 1ns / 1ps

module testbench;
	import fvn_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [31:0]      s_tdata;   // [15:0] coord_x, [31:16] coord_y
	logic             m_tvalid;
	logic             m_tready;
	logic [7:0]       m_tdata;   // [7:0] noise_byte
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data;

	int fail_count;
	int pending;
	int bytes_checked;
	bit idle_on;
	bit hold_req;
	int words_sent;
	int idle_cnt;
	int stall_cnt;

	fractal_value_noise_2d DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	fvn_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .bytes_checked(bytes_checked)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// receiver: random stall bursts, plus one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
			stall_cnt = 0;
		end else begin
			if (hold_req) begin
				hold_req = 0;
				stall_cnt = 500;
			end else if (stall_cnt == 0 && idle_on && $urandom_range(0, 5) == 0) begin
				stall_cnt = $urandom_range(1, 6);
			end
			if (stall_cnt > 0) begin
				m_tready <= 0;
				stall_cnt--;
			end else begin
				m_tready <= 1;
			end
		end
	end

	// watchdog: end the run if nothing moves for too long
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= 3000) begin
				$display("timeout after %0d quiet cycles", quiet);
				$display("testbench: errors");
				$finish;
			end
		end
	end

	// valid stays up between back-to-back words; drop it only to idle
	task automatic send_word(input logic [15:0] cx, input logic [15:0] cy);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {cy, cx};
		do @(posedge clk); while (!s_tready);
		words_sent++;
	endtask

	task automatic write_octaves(input logic [CNT_W-1:0] cnt);
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= cnt;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 255));
			1: return 16'($urandom_range(65280, 65535));
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [CNT_W-1:0] dir_oct [4];
		dir_oct = '{4'd0, 4'd8, 4'd15, 4'd1};
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		cfg_valid = 0;
		cfg_data = 0;
		idle_on = 1;
		hold_req = 0;
		words_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset setting first, then zero, maximum, saturating and single octave
		send_word(16'd0, 16'd0);
		send_word(16'hFFFF, 16'hFFFF);
		send_word(16'd63, 16'd64);
		foreach (dir_oct[j]) begin
			write_octaves(dir_oct[j]);
			send_word(16'd0, 16'd0);
			send_word(16'hFFFF, 16'd0);
			send_word(16'd0, 16'hFFFF);
			send_word(16'hFFFF, 16'hFFFF);
			send_word(16'h5555, 16'hAAAA);
		end

		// random phases over all settings; one long receiver hold-off that fills the block
		for (int ph = 0; ph < 9; ph++) begin
			write_octaves((ph == 0) ? 4'd8 : 4'($urandom_range(0, 15)));
			if (ph == 1)
				hold_req = 1;
			if (ph == 8)
				idle_on = 0;
			repeat ((ph == 1) ? 260 : 80) send_word(rand_coord(), rand_coord());
		end

		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("sent %0d coordinate words, checked %0d noise bytes", words_sent, bytes_checked);
		$display("octave settings 0, 1, 8, 15 and random values, with stalls on both sides");
		if (fail_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/fvn_pkg.sv
src/fvn_hash.sv
src/fvn_mulw.sv
src/fvn_cell.sv
src/fractal_value_noise_2d.sv
verif/fvn_checker.sv
verif/testbench.sv
